@@ hdl/mdsl_pkg.sv @@
// ----------------------------------------------------------------------------
// Motor duty slew limiter package
// Shared types and codes for the duty slew limiter.
// ----------------------------------------------------------------------------
package mdsl_pkg;

  localparam int unsigned DutyW   = 16;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned PdataW  = 32;

  localparam logic [DutyW-1:0]  RiseStepRst     = 16'd1310;
  localparam logic [DutyW-1:0]  FallStepRst     = 16'd1310;
  localparam logic [TicksW-1:0] ReleaseTicksRst = 16'd100;

  typedef enum logic [1:0] {
    DRIVE_FREE    = 2'd0,
    DRIVE_FORWARD = 2'd1,
    DRIVE_REVERSE = 2'd2,
    DRIVE_BRAKE   = 2'd3
  } drive_e;

  typedef enum logic [CmdW-1:0] {
    CMD_FRAME   = 2'd0,
    CMD_RAMP    = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_RISE_STEP     = 2'd0,
    REG_FALL_STEP     = 2'd1,
    REG_RELEASE_TICKS = 2'd2
  } reg_e;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic [1:0]       state;
  } drive_t;

  typedef struct packed {
    logic [DutyW-1:0] rise_step;
    logic [DutyW-1:0] fall_step;
  } slew_cfg_t;

endpackage

@@ hdl/mdsl_if.sv @@
// ----------------------------------------------------------------------------
// Motor duty slew limiter channels
// Valid/ready request and result channels of the duty slew limiter.
// ----------------------------------------------------------------------------
interface mdsl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] frame_byte0;
  logic [7:0] frame_byte1;
  logic [7:0] frame_byte2;

  modport source (output valid, cmd, frame_byte0, frame_byte1, frame_byte2, input ready);
  modport sink (input valid, cmd, frame_byte0, frame_byte1, frame_byte2, output ready);
endinterface

interface mdsl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] applied_duty_out;
  logic [1:0]  applied_state_out;
  logic        ready_out;
  logic        ack_out;

  modport source (output valid, applied_duty_out, applied_state_out, ready_out, ack_out,
                  input ready);
  modport sink (input valid, applied_duty_out, applied_state_out, ready_out, ack_out,
                output ready);
endinterface

@@ hdl/mdsl_ramp.sv @@
// ----------------------------------------------------------------------------
// Motor duty slew limiter ramp step
// One slew step of the applied drive toward the target drive.
// ----------------------------------------------------------------------------
module mdsl_ramp (
  input  logic               enable_i,
  input  mdsl_pkg::slew_cfg_t cfg_i,
  input  mdsl_pkg::drive_t   applied_i,
  input  mdsl_pkg::drive_t   target_i,
  output mdsl_pkg::drive_t   applied_o
);

  logic                       rising;
  logic [mdsl_pkg::DutyW-1:0] gap;
  logic [mdsl_pkg::DutyW-1:0] step;
  logic [mdsl_pkg::DutyW-1:0] stepped;
  logic                       passive;

  assign rising  = target_i.duty > applied_i.duty;
  assign gap     = rising ? (target_i.duty - applied_i.duty) : (applied_i.duty - target_i.duty);
  assign step    = rising ? cfg_i.rise_step : cfg_i.fall_step;
  assign stepped = rising ? (applied_i.duty + step) : (applied_i.duty - step);
  assign passive = (target_i.state == mdsl_pkg::DRIVE_FREE) ||
                   (target_i.state == mdsl_pkg::DRIVE_BRAKE);

  always_comb begin
    applied_o = applied_i;
    if (enable_i) begin
      if (applied_i.state != target_i.state) begin
        if (cfg_i.fall_step == '0) begin
          applied_o = target_i;
        end else if (applied_i.duty <= cfg_i.fall_step) begin
          applied_o.duty  = '0;
          applied_o.state = target_i.state;
        end else begin
          applied_o.duty = applied_i.duty - cfg_i.fall_step;
        end
      end else if ((applied_i.duty != target_i.duty) && !passive) begin
        if ((step == '0) || (gap < step)) begin
          applied_o.duty = target_i.duty;
        end else begin
          applied_o.duty = stepped;
        end
      end
    end
  end

endmodule

@@ hdl/motor_duty_slew_limiter_core.sv @@
// ----------------------------------------------------------------------------
// Motor duty slew limiter core
// Command frame decode, duty slew limiting and command timeout.
// ----------------------------------------------------------------------------
// Each request passes an input register and a result register; one request is
// taken every clock while results are taken. Its result moves from the input
// register into the result register once that one is free or being taken;
// the state update between them is combinational. A stalled result holds the
// input register and with it the request side. Every request yields exactly
// one result. The user writes step sizes and the timeout length over the APB
// port at byte addresses 0, 4 and 8 while idle; the block does not check it.
module motor_duty_slew_limiter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mdsl_in_if.sink                       in_i,
  mdsl_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mdsl_pkg::PaddrW-1:0]   paddr,
  input  logic [mdsl_pkg::PdataW-1:0]   pwdata,
  output logic [mdsl_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  logic [mdsl_pkg::DutyW-1:0]  rise_step_q;
  logic [mdsl_pkg::DutyW-1:0]  fall_step_q;
  logic [mdsl_pkg::TicksW-1:0] release_ticks_q;
  logic                        cfg_wr;
  mdsl_pkg::reg_e              cfg_idx;

  logic       req_valid_q;
  logic [1:0] req_cmd_q;
  logic [7:0] req_b0_q;
  logic [7:0] req_b1_q;
  logic [7:0] req_b2_q;
  logic       advance;

  mdsl_pkg::drive_t            target_q, target_d;
  mdsl_pkg::drive_t            applied_q, applied_d;
  mdsl_pkg::drive_t            ramp_target;
  mdsl_pkg::drive_t            ramp_result;
  mdsl_pkg::drive_t            frame_target;
  mdsl_pkg::slew_cfg_t         slew_cfg;
  logic [mdsl_pkg::TicksW-1:0] timeout_q, timeout_d;
  logic                        init_q, init_d;
  logic                        ack_d;
  logic                        ramp_en;

  logic                        res_valid_q;
  mdsl_pkg::drive_t            res_drive_q;
  logic                        res_init_q;
  logic                        res_ack_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = mdsl_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_step_q     <= mdsl_pkg::RiseStepRst;
      fall_step_q     <= mdsl_pkg::FallStepRst;
      release_ticks_q <= mdsl_pkg::ReleaseTicksRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mdsl_pkg::REG_RISE_STEP:     rise_step_q     <= pwdata[mdsl_pkg::DutyW-1:0];
        mdsl_pkg::REG_FALL_STEP:     fall_step_q     <= pwdata[mdsl_pkg::DutyW-1:0];
        mdsl_pkg::REG_RELEASE_TICKS: release_ticks_q <= pwdata[mdsl_pkg::TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mdsl_pkg::REG_RISE_STEP:     prdata = {16'd0, rise_step_q};
      mdsl_pkg::REG_FALL_STEP:     prdata = {16'd0, fall_step_q};
      mdsl_pkg::REG_RELEASE_TICKS: prdata = {16'd0, release_ticks_q};
      default:                     prdata = '0;
    endcase
  end

  assign advance    = req_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      req_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      req_cmd_q <= in_i.cmd;
      req_b0_q  <= in_i.frame_byte0;
      req_b1_q  <= in_i.frame_byte1;
      req_b2_q  <= in_i.frame_byte2;
    end
  end

  assign frame_target.duty  = {req_b0_q[6:0], req_b1_q, req_b2_q[7]};
  assign frame_target.state = req_b2_q[6:5];
  assign slew_cfg.rise_step = rise_step_q;
  assign slew_cfg.fall_step = fall_step_q;

  always_comb begin
    ramp_target = target_q;
    ramp_en     = 1'b0;
    case (mdsl_pkg::cmd_e'(req_cmd_q))
      mdsl_pkg::CMD_FRAME: begin
        ramp_target = frame_target;
        ramp_en     = !req_b0_q[7] && init_q;
      end
      mdsl_pkg::CMD_RAMP: ramp_en = init_q;
      default: ;
    endcase
  end

  mdsl_ramp u_ramp (
    .enable_i  (ramp_en),
    .cfg_i     (slew_cfg),
    .applied_i (applied_q),
    .target_i  (ramp_target),
    .applied_o (ramp_result)
  );

  always_comb begin
    target_d  = target_q;
    applied_d = ramp_result;
    timeout_d = timeout_q;
    init_d    = init_q;
    ack_d     = 1'b0;
    case (mdsl_pkg::cmd_e'(req_cmd_q))
      mdsl_pkg::CMD_FRAME: begin
        if (req_b0_q[7]) begin
          init_d          = 1'b1;
          applied_d.duty  = '0;
          applied_d.state = mdsl_pkg::DRIVE_FREE;
          ack_d           = !req_b0_q[6];
        end else begin
          target_d  = frame_target;
          timeout_d = release_ticks_q;
        end
      end
      mdsl_pkg::CMD_TIMEOUT: begin
        if (timeout_q == '0) begin
          target_d.duty  = '0;
          target_d.state = mdsl_pkg::DRIVE_BRAKE;
        end else begin
          timeout_d = timeout_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      applied_q   <= '0;
      timeout_q   <= '0;
      init_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        target_q    <= target_d;
        applied_q   <= applied_d;
        timeout_q   <= timeout_d;
        init_q      <= init_d;
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_drive_q <= applied_d;
      res_init_q  <= init_d;
      res_ack_q   <= ack_d;
    end
  end

  assign out_o.valid             = res_valid_q;
  assign out_o.applied_duty_out  = res_drive_q.duty;
  assign out_o.applied_state_out = res_drive_q.state;
  assign out_o.ready_out         = res_init_q;
  assign out_o.ack_out           = res_ack_q;

endmodule

@@ dv/mdsl_duty_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Duty slew limiter checker
// Watches the request, result and APB ports. It tracks the step sizes and the
// timeout length, predicts the bridge duty, drive state, ready and acknowledge
// for every accepted request, and compares each result with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module mdsl_duty_check
  import mdsl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  mdsl_in_if                 req_if,
  mdsl_out_if                res_if,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [PaddrW-1:0]  paddr_i,
  input  logic [PdataW-1:0]  pwdata_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic [1:0]       state;
    logic             rdy;
    logic             ack;
  } bridge_out_t;

  bridge_out_t      due_q[$];

  logic [DutyW-1:0]  rise_q;
  logic [DutyW-1:0]  fall_q;
  logic [TicksW-1:0] release_q;
  logic [TicksW-1:0] ticks_left;
  logic [DutyW-1:0]  tgt_duty;
  logic [DutyW-1:0]  drv_duty;
  drive_e            tgt_state;
  drive_e            drv_state;
  logic              armed;

  task automatic flag_mismatch(input string field, input int unsigned got,
                               input int unsigned want);
    $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, field, got, want);
    fail_count_o++;
  endtask

  task automatic slew_step();
    int delta;
    if (!armed) return;
    if (drv_state != tgt_state) begin
      if (fall_q == '0) begin
        drv_duty  = tgt_duty;
        drv_state = tgt_state;
      end else if (drv_duty <= fall_q) begin
        drv_duty  = '0;
        drv_state = tgt_state;
      end else begin
        drv_duty = drv_duty - fall_q;
      end
      return;
    end
    if (drv_duty == tgt_duty) return;
    if (tgt_state == DRIVE_FREE || tgt_state == DRIVE_BRAKE) return;
    delta = int'(tgt_duty) - int'(drv_duty);
    if (delta >= int'(rise_q)) begin
      drv_duty = (rise_q == '0) ? tgt_duty : drv_duty + rise_q;
    end else if (delta <= -int'(fall_q)) begin
      drv_duty = (fall_q == '0) ? tgt_duty : drv_duty - fall_q;
    end else begin
      drv_duty = tgt_duty;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bridge_out_t got;
    bridge_out_t want;
    logic        ack;
    if (!rst_ni) begin
      due_q.delete();
      rise_q       = RiseStepRst;
      fall_q       = FallStepRst;
      release_q    = ReleaseTicksRst;
      ticks_left   = '0;
      tgt_duty     = '0;
      drv_duty     = '0;
      tgt_state    = DRIVE_FREE;
      drv_state    = DRIVE_FREE;
      armed        = 1'b0;
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.applied_duty_out, res_if.applied_state_out, res_if.ready_out,
                res_if.ack_out};
        if (due_q.size() == 0) begin
          flag_mismatch("result with no request pending", got, 0);
        end else begin
          want = due_q.pop_front();
          if (got.duty !== want.duty) flag_mismatch("applied duty", got.duty, want.duty);
          if (got.state !== want.state) flag_mismatch("applied state", got.state, want.state);
          if (got.rdy !== want.rdy) flag_mismatch("ready flag", got.rdy, want.rdy);
          if (got.ack !== want.ack) flag_mismatch("ack flag", got.ack, want.ack);
        end
      end

      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_RISE_STEP:     rise_q    = pwdata_i[DutyW-1:0];
          REG_FALL_STEP:     fall_q    = pwdata_i[DutyW-1:0];
          REG_RELEASE_TICKS: release_q = pwdata_i[TicksW-1:0];
          default: ;
        endcase
      end

      if (req_if.valid && req_if.ready) begin
        ack = 1'b0;
        case (req_if.cmd)
          CMD_FRAME: begin
            if (req_if.frame_byte0[7]) begin
              armed     = 1'b1;
              drv_duty  = '0;
              drv_state = DRIVE_FREE;
              ack       = !req_if.frame_byte0[6];
            end else begin
              tgt_duty   = {req_if.frame_byte0[6:0], req_if.frame_byte1,
                            req_if.frame_byte2[7]};
              tgt_state  = drive_e'(req_if.frame_byte2[6:5]);
              ticks_left = release_q;
              slew_step();
            end
          end
          CMD_RAMP: slew_step();
          CMD_TIMEOUT: begin
            if (ticks_left == '0) begin
              tgt_state = DRIVE_BRAKE;
              tgt_duty  = '0;
            end else begin
              ticks_left = ticks_left - 1'b1;
            end
          end
          default: ;
        endcase
        due_q.push_back('{drv_duty, drv_state, armed, ack});
      end
      pending_o <= due_q.size();
    end
  end

endmodule

@@ dv/tb_motor_duty_slew_limiter_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Duty slew limiter testbench
// Drives command frames, ramp ticks and timeout ticks into the core under
// several step and timeout settings written over APB, with random gaps on the
// request side and random stalls on the result side. A checker beside the
// core predicts every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_motor_duty_slew_limiter_core;
  import mdsl_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 270;
  localparam int unsigned NumPhases  = 6;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  logic [DutyW-1:0]  rise_set    [NumPhases] = '{16'd1310, 16'd0, 16'd65535, 16'd1, 16'd4000,
                                                 16'd700};
  logic [DutyW-1:0]  fall_set    [NumPhases] = '{16'd1310, 16'd0, 16'd65535, 16'd1, 16'd300,
                                                 16'd9000};
  logic [TicksW-1:0] release_set [NumPhases] = '{16'd100, 16'd3, 16'd0, 16'd65535, 16'd8,
                                                 16'd2};

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       cycle_cnt = 0;
  bit                jitter_on = 1'b1;

  mdsl_in_if  req_ch ();
  mdsl_out_if res_ch ();

  motor_duty_slew_limiter_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_ch),
    .out_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mdsl_duty_check i_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_if       (req_ch),
    .res_if       (res_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("motor_duty_slew_limiter_core verification failed");
      $finish;
    end
  end

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (jitter_on && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
    end
  end

  task automatic apb_write(input reg_e idx, input logic [15:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_req(input logic [CmdW-1:0] cmd, input logic [7:0] b0,
                          input logic [7:0] b1, input logic [7:0] b2);
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= cmd;
    req_ch.frame_byte0 <= b0;
    req_ch.frame_byte1 <= b1;
    req_ch.frame_byte2 <= b2;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic send_frame(input logic [DutyW-1:0] duty, input drive_e state);
    send_req(CMD_FRAME, {1'b0, duty[15:9]}, duty[8:1], {duty[0], state, 5'($urandom)});
  endtask

  task automatic send_init(input logic no_ack);
    send_req(CMD_FRAME, {1'b1, no_ack, 6'($urandom)}, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_tick(input logic [CmdW-1:0] cmd);
    send_req(cmd, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned      pick;
    logic [DutyW-1:0] duty;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       duty = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1:       duty = 16'($urandom_range(0, 2000));
      default: duty = 16'($urandom);
    endcase
    if (pick < 3) send_init(1'($urandom));
    else if (pick < 5) send_tick(CmdUnused);
    else if (pick < 32) send_frame(duty, drive_e'($urandom_range(0, 3)));
    else if (pick < 70) send_tick(CMD_RAMP);
    else send_tick(CMD_TIMEOUT);
  endtask

  initial begin
    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= CMD_RAMP;
    req_ch.frame_byte0 <= 8'h00;
    req_ch.frame_byte1 <= 8'h00;
    req_ch.frame_byte2 <= 8'h00;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(CMD_TIMEOUT, 8'h00, 8'h00, 8'h00);
    send_frame(16'h4000, DRIVE_FORWARD);
    send_req(CMD_RAMP, 8'hFF, 8'hFF, 8'hFF);
    send_req(CmdUnused, 8'hFF, 8'hFF, 8'hFF);
    send_init(1'b0);
    send_init(1'b1);
    send_tick(CMD_RAMP);
    send_tick(CMD_RAMP);
    send_frame(16'hFFFF, DRIVE_FORWARD);
    send_tick(CMD_RAMP);
    send_frame(16'h0F00, DRIVE_FORWARD);
    send_frame(16'h8000, DRIVE_REVERSE);
    repeat (3) send_tick(CMD_RAMP);
    send_frame(16'h1234, DRIVE_BRAKE);
    send_tick(CMD_RAMP);
    send_frame(16'h0000, DRIVE_FREE);
    send_frame(16'h0000, DRIVE_FORWARD);
    send_tick(CMD_RAMP);
    repeat (2) send_tick(CMD_TIMEOUT);
    send_frame(16'h0001, DRIVE_FORWARD);
    drain();
    apb_write(REG_RELEASE_TICKS, 16'd0);
    send_frame(16'h2000, DRIVE_REVERSE);
    send_tick(CMD_TIMEOUT);
    send_tick(CMD_RAMP);
    send_tick(CMD_RAMP);
    drain();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      apb_write(REG_RISE_STEP, rise_set[ph]);
      apb_write(REG_FALL_STEP, fall_set[ph]);
      apb_write(REG_RELEASE_TICKS, release_set[ph]);
      jitter_on = (ph != NumPhases - 1);
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        if (k % 64 == 0 && ph != NumPhases - 1) jitter_on = ($urandom_range(0, 2) != 0);
        random_item();
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("motor_duty_slew_limiter_core verification clean");
    end else begin
      $display("motor_duty_slew_limiter_core verification failed");
    end
    $finish;
  end

endmodule
